FILE: design/dns_window_stats_accumulator_assert.svh
// Assertion macros shared by the accumulator modules.
// The using module must have clk and rst in scope.
`ifndef DNS_WINDOW_STATS_ACCUMULATOR_ASSERT_SVH
`define DNS_WINDOW_STATS_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define DWSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dws: property failed");
`define DWSA_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("dws: forbidden condition seen");
`else
`define DWSA_ASSERT(lbl, prop)
`define DWSA_NEVER(lbl, cond)
`endif
`endif

FILE: design/dws_pkg.sv
`default_nettype none
package dws_pkg;

  localparam int NUM_MODELS      = 2;
  localparam int NUM_RANK_LEVELS = 3;
  localparam int NUM_ZONES       = 4;

  // register file and port shapes are fixed
  localparam int MAX_MODELS = 2;
  localparam int NUM_LIMITS = 3;
  localparam int NUM_EDGES  = 5;
  localparam int NUM_TOTALS = 5;

  localparam int COUNT_W    = 16;
  localparam int RANK_W     = 24;
  localparam int SCORE_W    = 17;
  localparam int LOGIT_W    = 24;
  localparam int IDX_W      = 5;
  localparam int CNT_W      = 32;
  localparam int SUM_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int LVL_CNT_W  = $clog2(NUM_RANK_LEVELS + 1);

  localparam int QUEUE_DEPTH = 4;

  localparam logic [SCORE_W-1:0] SCORE_ZERO = '0;
  localparam logic [SCORE_W-1:0] SCORE_ONE  = SCORE_W'(65536);

  localparam logic [RANK_W-1:0] RANK_LIMIT_RST [NUM_LIMITS] = '{
    RANK_W'(100), RANK_W'(10000), RANK_W'(1000000)
  };
  localparam logic [SCORE_W-1:0] ZONE_EDGE_RST [NUM_EDGES] = '{
    SCORE_W'(0), SCORE_W'(16384), SCORE_W'(32768), SCORE_W'(49152), SCORE_W'(65537)
  };

  // read slot layout
  localparam int SLOT_TOTAL  = 0;
  localparam int SLOT_WL     = 5;
  localparam int SLOT_ZONE   = 8;
  localparam int SLOT_ZERO   = 16;
  localparam int SLOT_ONE    = 18;
  localparam int SLOT_SUM    = 20;
  localparam int ZONE_STRIDE = 4;
  localparam int SUM_STRIDE  = 3;

  localparam int TOT_GROUP    = 0;
  localparam int TOT_RECORDS  = 1;
  localparam int TOT_QUERY    = 2;
  localparam int TOT_RESPONSE = 3;
  localparam int TOT_NXDOMAIN = 4;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_READ   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANK_LIMIT_0 = 3'd0,
    CFG_RANK_LIMIT_1 = 3'd1,
    CFG_RANK_LIMIT_2 = 3'd2,
    CFG_ZONE_EDGE_0  = 3'd3,
    CFG_ZONE_EDGE_1  = 3'd4,
    CFG_ZONE_EDGE_2  = 3'd5,
    CFG_ZONE_EDGE_3  = 3'd6,
    CFG_ZONE_EDGE_4  = 3'd7
  } cfg_reg_t;

  // classified item as it travels from front to back
  typedef struct packed {
    kind_t                                     kind;
    logic [COUNT_W-1:0]                        group_count;
    logic [COUNT_W-1:0]                        query_count;
    logic [COUNT_W-1:0]                        response_count;
    logic [COUNT_W-1:0]                        nxdomain_count;
    logic [NUM_RANK_LEVELS-1:0]                wl;
    logic [NUM_MODELS-1:0][NUM_ZONES-1:0]      zone_hit;
    logic [NUM_MODELS-1:0][LVL_CNT_W-1:0]      zero_inc;
    logic [NUM_MODELS-1:0][LVL_CNT_W-1:0]      one_inc;
    logic [NUM_MODELS-1:0][NUM_RANK_LEVELS-1:0] sum_en;
    logic [NUM_MODELS-1:0][LOGIT_W-1:0]        logit;
    logic [IDX_W-1:0]                          read_index;
  } op_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage
`default_nettype wire

FILE: design/dws_queue.sv
`default_nettype none
`include "dns_window_stats_accumulator_assert.svh"
module dws_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dws_pkg::op_t       push_op,
  input  logic               pop,
  output dws_pkg::op_t       head_op,
  output dws_pkg::q_status_t status
);

  localparam int PTR_W = $clog2(dws_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(dws_pkg::QUEUE_DEPTH + 1);

  dws_pkg::op_t     entries [dws_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(dws_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(dws_pkg::QUEUE_DEPTH));
  assign head_op      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `DWSA_NEVER(a_push_when_full, push && status.full)
  `DWSA_NEVER(a_pop_when_empty, pop && status.empty)
  `DWSA_ASSERT(a_fill_step, push && !pop |=> count == $past(count) + 1'b1)

endmodule
`default_nettype wire

FILE: design/dws_front.sv
`default_nettype none
module dws_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [dws_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dws_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          kind,
  input  logic [dws_pkg::COUNT_W-1:0]         group_count,
  input  logic [dws_pkg::COUNT_W-1:0]         query_count,
  input  logic [dws_pkg::COUNT_W-1:0]         response_count,
  input  logic [dws_pkg::COUNT_W-1:0]         nxdomain_count,
  input  logic [dws_pkg::RANK_W-1:0]          list_rank,
  input  logic [dws_pkg::SCORE_W-1:0]         score_a,
  input  logic [dws_pkg::SCORE_W-1:0]         score_b,
  input  logic signed [dws_pkg::LOGIT_W-1:0]  logit_a,
  input  logic signed [dws_pkg::LOGIT_W-1:0]  logit_b,
  input  logic [dws_pkg::IDX_W-1:0]           read_index,
  input  dws_pkg::q_status_t                  q_status,
  output logic                                push,
  output dws_pkg::op_t                        push_op
);

  logic [dws_pkg::RANK_W-1:0]  rank_limit [dws_pkg::NUM_LIMITS];
  logic [dws_pkg::SCORE_W-1:0] zone_edge  [dws_pkg::NUM_EDGES];

  logic [dws_pkg::SCORE_W-1:0] score [dws_pkg::MAX_MODELS];
  logic [dws_pkg::LOGIT_W-1:0] logit [dws_pkg::MAX_MODELS];
  logic [dws_pkg::LVL_CNT_W-1:0] open_levels;
  logic [dws_pkg::NUM_MODELS-1:0] is_zero;
  logic [dws_pkg::NUM_MODELS-1:0] is_one;
  logic kind_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_limit <= dws_pkg::RANK_LIMIT_RST;
      zone_edge  <= dws_pkg::ZONE_EDGE_RST;
    end else if (cfg_write) begin
      case (dws_pkg::cfg_reg_t'(cfg_index))
        dws_pkg::CFG_RANK_LIMIT_0: rank_limit[0] <= cfg_data;
        dws_pkg::CFG_RANK_LIMIT_1: rank_limit[1] <= cfg_data;
        dws_pkg::CFG_RANK_LIMIT_2: rank_limit[2] <= cfg_data;
        dws_pkg::CFG_ZONE_EDGE_0:  zone_edge[0]  <= cfg_data[dws_pkg::SCORE_W-1:0];
        dws_pkg::CFG_ZONE_EDGE_1:  zone_edge[1]  <= cfg_data[dws_pkg::SCORE_W-1:0];
        dws_pkg::CFG_ZONE_EDGE_2:  zone_edge[2]  <= cfg_data[dws_pkg::SCORE_W-1:0];
        dws_pkg::CFG_ZONE_EDGE_3:  zone_edge[3]  <= cfg_data[dws_pkg::SCORE_W-1:0];
        dws_pkg::CFG_ZONE_EDGE_4:  zone_edge[4]  <= cfg_data[dws_pkg::SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  assign score[0] = score_a;
  assign score[1] = score_b;
  assign logit[0] = logit_a;
  assign logit[1] = logit_b;

  always_comb begin
    push_op                = '0;
    push_op.kind           = dws_pkg::kind_t'(kind);
    push_op.group_count    = group_count;
    push_op.query_count    = query_count;
    push_op.response_count = response_count;
    push_op.nxdomain_count = nxdomain_count;
    push_op.read_index     = read_index;
    open_levels            = '0;
    for (int l = 0; l < dws_pkg::NUM_RANK_LEVELS; l++) begin
      push_op.wl[l] = (list_rank < rank_limit[l]);
      open_levels   = open_levels + dws_pkg::LVL_CNT_W'(!push_op.wl[l]);
    end
    for (int m = 0; m < dws_pkg::NUM_MODELS; m++) begin
      is_zero[m] = (score[m] == dws_pkg::SCORE_ZERO);
      is_one[m]  = (score[m] == dws_pkg::SCORE_ONE);
      push_op.logit[m] = logit[m];
      // zones are half-open; disordered edges may hit several or none
      for (int z = 0; z < dws_pkg::NUM_ZONES; z++) begin
        push_op.zone_hit[m][z] = (score[m] >= zone_edge[z]) && (score[m] < zone_edge[z+1]);
      end
      // zero/one counters rise once per open level
      push_op.zero_inc[m] = is_zero[m] ? open_levels : '0;
      push_op.one_inc[m]  = is_one[m]  ? open_levels : '0;
      for (int l = 0; l < dws_pkg::NUM_RANK_LEVELS; l++) begin
        push_op.sum_en[m][l] = !push_op.wl[l] && !is_zero[m] && !is_one[m];
      end
    end
  end

  // unused kind is taken and dropped
  assign kind_ok  = (kind == dws_pkg::KIND_RECORD) || (kind == dws_pkg::KIND_READ) ||
                    (kind == dws_pkg::KIND_CLEAR);
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full && kind_ok;

endmodule
`default_nettype wire

FILE: design/dws_back.sv
`default_nettype none
`include "dns_window_stats_accumulator_assert.svh"
module dws_back (
  input  logic                              clk,
  input  logic                              rst,
  input  dws_pkg::op_t                      head_op,
  input  dws_pkg::q_status_t                q_status,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [dws_pkg::SUM_W-1:0]  read_value,
  output logic                              index_bad
);

  localparam int CW = dws_pkg::CNT_W;
  localparam int SW = dws_pkg::SUM_W;
  localparam int LW = dws_pkg::LOGIT_W;
  localparam int NM = dws_pkg::NUM_MODELS;
  localparam int NL = dws_pkg::NUM_RANK_LEVELS;
  localparam int NZ = dws_pkg::NUM_ZONES;

  logic [CW-1:0] total_cnt [dws_pkg::NUM_TOTALS];
  logic [CW-1:0] wl_cnt    [NL];
  logic [CW-1:0] zone_cnt  [NM][NZ];
  logic [CW-1:0] zero_cnt  [NM];
  logic [CW-1:0] one_cnt   [NM];
  logic [SW-1:0] sum       [NM][NL];

  logic [CW-1:0] total_cnt_next [dws_pkg::NUM_TOTALS];
  logic [CW-1:0] wl_cnt_next    [NL];
  logic [CW-1:0] zone_cnt_next  [NM][NZ];
  logic [CW-1:0] zero_cnt_next  [NM];
  logic [CW-1:0] one_cnt_next   [NM];
  logic [SW-1:0] sum_next       [NM][NL];

  logic [SW-1:0] rd_val;
  logic          rd_hit;
  logic          out_free;

  function automatic logic [CW-1:0] sat_cnt(input logic [CW-1:0] a,
                                            input logic [dws_pkg::COUNT_W-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + (CW+1)'(b);
    return s[CW] ? '1 : s[CW-1:0];
  endfunction

  function automatic logic [SW-1:0] sat_sum(input logic [SW-1:0] a, input logic [LW-1:0] b);
    logic [SW:0] s;
    s = {a[SW-1], a} + {{(SW+1-LW){b[LW-1]}}, b};
    if (s[SW] != s[SW-1]) begin
      return s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    return s[SW-1:0];
  endfunction

  // a read at the head waits for the output register; other items never do
  assign out_free = !out_valid || !out_stall;
  assign pop = !q_status.empty && (head_op.kind != dws_pkg::KIND_READ || out_free);

  always_comb begin
    total_cnt_next[dws_pkg::TOT_GROUP] =
      sat_cnt(total_cnt[dws_pkg::TOT_GROUP], head_op.group_count);
    total_cnt_next[dws_pkg::TOT_RECORDS] =
      sat_cnt(total_cnt[dws_pkg::TOT_RECORDS], dws_pkg::COUNT_W'(1));
    total_cnt_next[dws_pkg::TOT_QUERY] =
      sat_cnt(total_cnt[dws_pkg::TOT_QUERY], head_op.query_count);
    total_cnt_next[dws_pkg::TOT_RESPONSE] =
      sat_cnt(total_cnt[dws_pkg::TOT_RESPONSE], head_op.response_count);
    total_cnt_next[dws_pkg::TOT_NXDOMAIN] =
      sat_cnt(total_cnt[dws_pkg::TOT_NXDOMAIN], head_op.nxdomain_count);
    for (int l = 0; l < NL; l++) begin
      wl_cnt_next[l] = sat_cnt(wl_cnt[l], dws_pkg::COUNT_W'(head_op.wl[l]));
    end
    for (int m = 0; m < NM; m++) begin
      for (int z = 0; z < NZ; z++) begin
        zone_cnt_next[m][z] = sat_cnt(zone_cnt[m][z], dws_pkg::COUNT_W'(head_op.zone_hit[m][z]));
      end
      zero_cnt_next[m] = sat_cnt(zero_cnt[m], dws_pkg::COUNT_W'(head_op.zero_inc[m]));
      one_cnt_next[m]  = sat_cnt(one_cnt[m], dws_pkg::COUNT_W'(head_op.one_inc[m]));
      for (int l = 0; l < NL; l++) begin
        sum_next[m][l] = head_op.sum_en[m][l] ? sat_sum(sum[m][l], head_op.logit[m]) : sum[m][l];
      end
    end
  end

  always_comb begin
    rd_val = '0;
    rd_hit = 1'b0;
    for (int t = 0; t < dws_pkg::NUM_TOTALS; t++) begin
      if (head_op.read_index == dws_pkg::IDX_W'(dws_pkg::SLOT_TOTAL + t)) begin
        rd_val = SW'(total_cnt[t]);
        rd_hit = 1'b1;
      end
    end
    for (int l = 0; l < NL; l++) begin
      if (head_op.read_index == dws_pkg::IDX_W'(dws_pkg::SLOT_WL + l)) begin
        rd_val = SW'(wl_cnt[l]);
        rd_hit = 1'b1;
      end
    end
    for (int m = 0; m < NM; m++) begin
      for (int z = 0; z < NZ; z++) begin
        if (head_op.read_index ==
            dws_pkg::IDX_W'(dws_pkg::SLOT_ZONE + m * dws_pkg::ZONE_STRIDE + z)) begin
          rd_val = SW'(zone_cnt[m][z]);
          rd_hit = 1'b1;
        end
      end
      if (head_op.read_index == dws_pkg::IDX_W'(dws_pkg::SLOT_ZERO + m)) begin
        rd_val = SW'(zero_cnt[m]);
        rd_hit = 1'b1;
      end
      if (head_op.read_index == dws_pkg::IDX_W'(dws_pkg::SLOT_ONE + m)) begin
        rd_val = SW'(one_cnt[m]);
        rd_hit = 1'b1;
      end
      for (int l = 0; l < NL; l++) begin
        if (head_op.read_index ==
            dws_pkg::IDX_W'(dws_pkg::SLOT_SUM + m * dws_pkg::SUM_STRIDE + l)) begin
          rd_val = sum[m][l];
          rd_hit = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && head_op.kind == dws_pkg::KIND_CLEAR)) begin
      for (int t = 0; t < dws_pkg::NUM_TOTALS; t++) total_cnt[t] <= '0;
      for (int l = 0; l < NL; l++) wl_cnt[l] <= '0;
      for (int m = 0; m < NM; m++) begin
        for (int z = 0; z < NZ; z++) zone_cnt[m][z] <= '0;
        zero_cnt[m] <= '0;
        one_cnt[m]  <= '0;
        for (int l = 0; l < NL; l++) sum[m][l] <= '0;
      end
    end else if (pop && head_op.kind == dws_pkg::KIND_RECORD) begin
      total_cnt <= total_cnt_next;
      wl_cnt    <= wl_cnt_next;
      zone_cnt  <= zone_cnt_next;
      zero_cnt  <= zero_cnt_next;
      one_cnt   <= one_cnt_next;
      sum       <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head_op.kind == dws_pkg::KIND_READ) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_op.kind == dws_pkg::KIND_READ) begin
      read_value <= rd_val;
      index_bad  <= !rd_hit;
    end
  end

  `DWSA_NEVER(a_bad_index_nonzero, out_valid && index_bad && read_value != '0)
  `DWSA_ASSERT(a_clear_zeroes, pop && head_op.kind == dws_pkg::KIND_CLEAR |=>
    total_cnt[dws_pkg::TOT_RECORDS] == '0)
  `DWSA_ASSERT(a_record_counts, pop && head_op.kind == dws_pkg::KIND_RECORD &&
    total_cnt[dws_pkg::TOT_RECORDS] != '1 |=>
    total_cnt[dws_pkg::TOT_RECORDS] == $past(total_cnt[dws_pkg::TOT_RECORDS]) + 1'b1)

endmodule
`default_nettype wire

FILE: design/dns_window_stats_accumulator.sv
// DNS window statistics accumulator.
// Input channel (in_valid / in_stall) carries one item per transfer: kind selects a
// message record, a read of one accumulator (read_index), or a clear of all of them.
// Output channel (out_valid / out_stall) carries one result per read: read_value and
// index_bad; records and clears give no result, and kind 3 is taken and dropped.
// Rank limits and zone edges are written through cfg_write / cfg_index / cfg_data;
// the user must write them only while the block is idle; the block does not enforce it.
// Throughput: one item per cycle while no stall holds the flow. The front classifies an
// item in the cycle it is taken and writes it into a four-entry queue; the back retires
// one queue entry a cycle, so the accumulator bank with its saturating adds sets the rate.
// A read result passes through the queue and the output register, and reflects every
// item taken before it.
// When the receiver stalls, the result is held; records and clears behind it carry on,
// a read reaching the queue head waits, and in_stall rises once the queue is full.
// Reset (rst, synchronous) zeroes all accumulators, empties the queue and returns the
// rank limits to 100, 10000, 1000000 and the zone edges to 0, 16384, 32768, 49152, 65537.
`default_nettype none
module dns_window_stats_accumulator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [dws_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dws_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          kind,
  input  logic [dws_pkg::COUNT_W-1:0]         group_count,
  input  logic [dws_pkg::COUNT_W-1:0]         query_count,
  input  logic [dws_pkg::COUNT_W-1:0]         response_count,
  input  logic [dws_pkg::COUNT_W-1:0]         nxdomain_count,
  input  logic [dws_pkg::RANK_W-1:0]          list_rank,
  input  logic [dws_pkg::SCORE_W-1:0]         score_a,
  input  logic [dws_pkg::SCORE_W-1:0]         score_b,
  input  logic signed [dws_pkg::LOGIT_W-1:0]  logit_a,
  input  logic signed [dws_pkg::LOGIT_W-1:0]  logit_b,
  input  logic [dws_pkg::IDX_W-1:0]           read_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dws_pkg::SUM_W-1:0]    read_value,
  output logic                                index_bad
);

  dws_pkg::q_status_t q_status;
  dws_pkg::op_t       push_op;
  dws_pkg::op_t       head_op;
  logic               push;
  logic               pop;

  dws_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .group_count    (group_count),
    .query_count    (query_count),
    .response_count (response_count),
    .nxdomain_count (nxdomain_count),
    .list_rank      (list_rank),
    .score_a        (score_a),
    .score_b        (score_b),
    .logit_a        (logit_a),
    .logit_b        (logit_b),
    .read_index     (read_index),
    .q_status       (q_status),
    .push           (push),
    .push_op        (push_op)
  );

  dws_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .status  (q_status)
  );

  dws_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_op    (head_op),
    .q_status   (q_status),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .index_bad  (index_bad)
  );

endmodule
`default_nettype wire
